@@ rtl/core/ignition_pulse_tachometer_unit_macros.svh @@
// Assertion macros shared by the tachometer RTL.
// Both macros expect a clock named clk in scope; IPT_ASSERT also expects an active-low reset named rst_n.
`ifndef IGNITION_PULSE_TACHOMETER_UNIT_MACROS_SVH
`define IGNITION_PULSE_TACHOMETER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define IPT_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("ipt assertion failed");
`define IPT_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("ipt assertion failed");
`else
`define IPT_ASSERT(lbl, prop)
`define IPT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

@@ rtl/core/ipt_pkg.sv @@
package ipt_pkg;

  localparam int IN_TIME_W  = 32;
  localparam int OUT_W      = 16;
  localparam int WINDOW_W   = 24;
  localparam int PPR_W      = 5;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;
  localparam int MINUTE_W   = 26;
  localparam int STEP_W     = $clog2(OUT_W);

  localparam logic [MINUTE_W-1:0]   US_PER_MIN     = MINUTE_W'(60000000);
  localparam logic [WINDOW_W-1:0]   WINDOW_RESET   = WINDOW_W'(200000);
  localparam logic [PPR_W-1:0]      PPR_RESET      = PPR_W'(4);
  localparam logic [CFG_IDX_W-1:0]  CFG_WINDOW_US  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  CFG_PULSES_REV = CFG_IDX_W'(1);

  typedef struct packed {
    logic load;      // take the item's timestamp and count the pulse
    logic close;     // window closes: form product terms, restart window
    logic sat_init;  // saturation test and divider set-up
    logic step;      // one restoring division step
    logic emit;      // load the output register
  } ipt_cmd_t;

  typedef struct packed {
    logic close;     // elapsed time exceeds the window
    logic sat;       // quotient would not fit in the result width
  } ipt_sts_t;

endpackage

@@ rtl/core/ipt_in_if.sv @@
interface ipt_in_if;
  logic                           valid;
  logic                           ready;
  logic [ipt_pkg::IN_TIME_W-1:0]  pulse_time_us;

  modport source (output valid, output pulse_time_us, input ready);
  modport sink   (input valid, input pulse_time_us, output ready);
endinterface

@@ rtl/core/ipt_out_if.sv @@
interface ipt_out_if;
  logic                       valid;
  logic                       ready;
  logic [ipt_pkg::OUT_W-1:0]  engine_speed_rpm;
  logic [ipt_pkg::OUT_W-1:0]  pulses_counted;

  modport source (output valid, output engine_speed_rpm, output pulses_counted, input ready);
  modport sink   (input valid, input engine_speed_rpm, input pulses_counted, output ready);
endinterface

@@ rtl/core/ignition_pulse_tachometer_unit.sv @@
// Channel   Direction  Payload
// in_chan   sink       pulse_time_us (32 bit timestamp of one ignition pulse)
// out_chan  source     engine_speed_rpm, pulses_counted (16 bit each)
// cfg_*     write      index 0 window_us, index 1 pulses_per_rev
//
// An item that does not close the window passes through the check state and back to idle;
// one that closes it runs the 16-step restoring divider that forms the speed figure,
// or skips the divider when the figure saturates.
// Reset is synchronous and active low; no clearing pass is needed after it.
// A finished result sits in the output register while the next item is accepted;
// the divider waits in its final state only if that register is still full.
`include "ignition_pulse_tachometer_unit_macros.svh"

module ignition_pulse_tachometer_unit #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [ipt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ipt_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  ipt_in_if.sink                          in_chan,
  ipt_out_if.source                       out_chan
);

  ipt_pkg::ipt_cmd_t  cmd;
  ipt_pkg::ipt_sts_t  sts;
  logic               in_ready;
  logic               out_valid;

  ipt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_chan.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ipt_dp #(
    .TIME_BITS  (TIME_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_time   (in_chan.pulse_time_us),
    .cmd       (cmd),
    .sts       (sts),
    .speed     (out_chan.engine_speed_rpm),
    .pcount    (out_chan.pulses_counted)
  );

  assign in_chan.ready  = in_ready;
  assign out_chan.valid = out_valid;

endmodule

@@ rtl/core/ipt_ctrl.sv @@
`include "ignition_pulse_tachometer_unit_macros.svh"

module ipt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  ipt_pkg::ipt_sts_t sts,
  output ipt_pkg::ipt_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SAT,
    S_DIV,
    S_DONE
  } state_t;

  state_t                      state_r;
  logic [ipt_pkg::STEP_W-1:0]  step_cnt_r;
  logic                        out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.close    = (state_r == S_CHECK) && sts.close;
    cmd.sat_init = (state_r == S_SAT);
    cmd.step     = (state_r == S_DIV);
    cmd.emit     = (state_r == S_DONE) && (!out_valid_r || out_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_cnt_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r <= S_CHECK;
          end
        end
        S_CHECK: begin
          state_r <= sts.close ? S_SAT : S_IDLE;
        end
        S_SAT: begin
          step_cnt_r <= '1;
          state_r    <= sts.sat ? S_DONE : S_DIV;
        end
        S_DIV: begin
          if (step_cnt_r == '0) begin
            state_r <= S_DONE;
          end else begin
            step_cnt_r <= step_cnt_r - 1'b1;
          end
        end
        S_DONE: begin
          if (cmd.emit) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `IPT_ASSERT(a_accept_to_check, (in_valid && in_ready) |=> (state_r == S_CHECK))
  `IPT_ASSERT(a_div_ends_done, (state_r == S_DIV && step_cnt_r == '0) |=> (state_r == S_DONE))
  `IPT_ASSERT(a_result_from_done, $rose(out_valid_r) |-> ($past(state_r) == S_DONE))

endmodule

@@ rtl/core/ipt_dp.sv @@
`include "ignition_pulse_tachometer_unit_macros.svh"

module ipt_dp #(
  parameter int TIME_BITS  = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [ipt_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ipt_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  logic [ipt_pkg::IN_TIME_W-1:0]      in_time,
  input  ipt_pkg::ipt_cmd_t                  cmd,
  output ipt_pkg::ipt_sts_t                  sts,
  output logic [ipt_pkg::OUT_W-1:0]          speed,
  output logic [ipt_pkg::OUT_W-1:0]          pcount
);

  localparam int OUT_W  = ipt_pkg::OUT_W;
  localparam int NUM_W  = COUNT_BITS + ipt_pkg::MINUTE_W;
  localparam int DEN_W  = TIME_BITS + ipt_pkg::PPR_W;
  localparam int DIV_A  = DEN_W + OUT_W;
  localparam int DIV_W  = (NUM_W > DIV_A) ? NUM_W : DIV_A;
  localparam int EXT_W  = TIME_BITS + ipt_pkg::IN_TIME_W;
  localparam int CW     = COUNT_BITS + OUT_W;

  logic [ipt_pkg::WINDOW_W-1:0]  window_r;
  logic [ipt_pkg::PPR_W-1:0]     ppr_r;
  logic [COUNT_BITS-1:0]         cnt_r;
  logic [TIME_BITS-1:0]          start_r;
  logic [TIME_BITS-1:0]          now_r;
  logic [TIME_BITS-1:0]          elapsed_r;
  logic [NUM_W-1:0]              num_r;
  logic [DEN_W-1:0]              den_r;
  logic [NUM_W-1:0]              rem_r;
  logic [DIV_W-1:0]              dsh_r;
  logic [OUT_W-1:0]              quo_r;
  logic [OUT_W-1:0]              pcnt_hold_r;
  logic [OUT_W-1:0]              speed_r;
  logic [OUT_W-1:0]              pcount_r;

  logic [EXT_W-1:0]              now_ext;
  logic [TIME_BITS-1:0]          now;
  logic [COUNT_BITS-1:0]         cnt_nxt;
  logic [ipt_pkg::PPR_W-1:0]     ppr_eff;
  logic [CW-1:0]                 cnt_wide;
  logic [OUT_W-1:0]              cnt_sat;
  logic [DIV_W-1:0]              den_top;
  logic [DIV_W-1:0]              rem_wide;
  logic                          take;

  // Zero-extend then truncate, so any time width from 24 to 64 bits works.
  assign now_ext = {TIME_BITS'(0), in_time};
  assign now     = now_ext[TIME_BITS-1:0];
  assign cnt_nxt = (cnt_r != '1) ? cnt_r + 1'b1 : cnt_r;
  assign ppr_eff = (ppr_r == '0) ? ipt_pkg::PPR_W'(1) : ppr_r;

  assign cnt_wide = CW'(cnt_r);
  assign cnt_sat  = (cnt_wide > CW'({OUT_W{1'b1}})) ? '1 : cnt_wide[OUT_W-1:0];

  assign den_top  = DIV_W'(den_r) << OUT_W;
  assign rem_wide = DIV_W'(rem_r);
  assign take     = rem_wide >= dsh_r;

  assign sts.close = elapsed_r > TIME_BITS'(window_r);
  assign sts.sat   = den_top <= DIV_W'(num_r);

  assign speed  = speed_r;
  assign pcount = pcount_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= ipt_pkg::WINDOW_RESET;
      ppr_r    <= ipt_pkg::PPR_RESET;
      cnt_r    <= '0;
      start_r  <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          ipt_pkg::CFG_WINDOW_US:  window_r <= cfg_wdata[ipt_pkg::WINDOW_W-1:0];
          ipt_pkg::CFG_PULSES_REV: ppr_r    <= cfg_wdata[ipt_pkg::PPR_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        cnt_r <= cnt_nxt;
      end else if (cmd.close) begin
        cnt_r   <= '0;
        start_r <= now_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      now_r     <= now;
      elapsed_r <= now - start_r;
    end
    if (cmd.close) begin
      // The count still holds this pulse here; it is cleared at the same edge.
      num_r       <= NUM_W'(cnt_r) * NUM_W'(ipt_pkg::US_PER_MIN);
      den_r       <= DEN_W'(elapsed_r) * DEN_W'(ppr_eff);
      pcnt_hold_r <= cnt_sat;
    end
    if (cmd.sat_init) begin
      rem_r <= num_r;
      dsh_r <= DIV_W'(den_r) << (OUT_W - 1);
      quo_r <= sts.sat ? '1 : '0;
    end else if (cmd.step) begin
      if (take) begin
        rem_r <= rem_r - NUM_W'(dsh_r);
      end
      dsh_r <= dsh_r >> 1;
      quo_r <= {quo_r[OUT_W-2:0], take};
    end
    if (cmd.emit) begin
      speed_r  <= quo_r;
      pcount_r <= pcnt_hold_r;
    end
  end

  `IPT_ASSERT(a_close_clears, cmd.close |=> (cnt_r == '0))
  `IPT_ASSERT(a_load_counts, cmd.load |=> (cnt_r != '0))
  `IPT_ASSERT(a_rem_shrinks, cmd.step |=> (rem_r <= $past(rem_r)))

endmodule
